// ===== hw/rtl/sbsh_pkg.sv =====
package sbsh_pkg;

  // compare result codes for exact rational compares
  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

endpackage

// ===== hw/rtl/segment_box_slab_hit_test_unit.sv =====
// Segment versus axis-aligned box hit test. Each item is a 2D segment (start, end)
// and a box given as origin plus signed size, all two's complement coordinates of
// COORD_WIDTH bits taken from the low bits of the 32-bit fields. The result is one
// hit bit: set when an endpoint lies inside the box (inclusive) or the slab
// crossing parameter falls strictly inside (0,1). The design is a six-stage
// pipeline that takes one item per clock and returns one result per clock
// while the output is not stalled. The depth is set by the two chained exact
// rational compares (picking the entry and exit bounds, then entry against
// exit), each needing a product stage before its compare stage. A stall on the
// output freezes the whole pipeline, so nothing is lost or repeated.
module segment_box_slab_hit_test_unit
  import sbsh_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic [31:0] in_box_origin_x,
  input  logic [31:0] in_box_origin_y,
  input  logic [31:0] in_box_size_x,
  input  logic [31:0] in_box_size_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit
);

  localparam int CW = COORD_WIDTH;
  // differences of corners and points need two extra bits
  localparam int DW = CW + 2;
  localparam int PW = 2 * DW;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [CW:0]   bnd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] prd_t;

  // the pipeline advances whenever the output is not stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // field extraction and sign extension to the coordinate width
  function automatic crd_t fld(input logic [31:0] v);
    logic [47:0] w;
    begin
      w   = {{16{v[31]}}, v};
      fld = crd_t'(w[CW-1:0]);
    end
  endfunction

  // sign of a difference
  function automatic logic [1:0] cmp3(input prd_t a, input prd_t b);
    begin
      if (a < b)       cmp3 = CMP_LT;
      else if (a == b) cmp3 = CMP_EQ;
      else             cmp3 = CMP_GT;
    end
  endfunction

  // stage 1: box bounds
  logic v1_r;
  bnd_t s1x_r, s1y_r, e1x_r, e1y_r, lo1x_r, lo1y_r, hi1x_r, hi1y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    bnd_t ox, oy, cx, cy;
    if (adv) begin
      ox = bnd_t'(fld(in_box_origin_x));
      oy = bnd_t'(fld(in_box_origin_y));
      cx = ox + bnd_t'(fld(in_box_size_x));
      cy = oy + bnd_t'(fld(in_box_size_y));
      s1x_r  <= bnd_t'(fld(in_start_x));
      s1y_r  <= bnd_t'(fld(in_start_y));
      e1x_r  <= bnd_t'(fld(in_end_x));
      e1y_r  <= bnd_t'(fld(in_end_y));
      lo1x_r <= (ox < cx) ? ox : cx;
      hi1x_r <= (ox < cx) ? cx : ox;
      lo1y_r <= (oy < cy) ? oy : cy;
      hi1y_r <= (oy < cy) ? cy : oy;
    end
  end

  // stage 2: endpoint tests and slab numerators per axis
  logic v2_r, in2_r, miss2_r, bx2_r, by2_r;
  dif_t lonx2_r, hinx2_r, denx2_r, lony2_r, hiny2_r, deny2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    logic sin_x, sin_y, ein_x, ein_y;
    dif_t dx, dy;
    if (adv) begin
      sin_x = (s1x_r >= lo1x_r) && (s1x_r <= hi1x_r);
      sin_y = (s1y_r >= lo1y_r) && (s1y_r <= hi1y_r);
      ein_x = (e1x_r >= lo1x_r) && (e1x_r <= hi1x_r);
      ein_y = (e1y_r >= lo1y_r) && (e1y_r <= hi1y_r);
      dx = dif_t'(e1x_r) - dif_t'(s1x_r);
      dy = dif_t'(e1y_r) - dif_t'(s1y_r);
      in2_r   <= (sin_x && sin_y) || (ein_x && ein_y);
      bx2_r   <= (dx != '0);
      by2_r   <= (dy != '0);
      miss2_r <= ((dx == '0) && !sin_x) || ((dy == '0) && !sin_y);
      denx2_r <= dx[DW-1] ? -dx : dx;
      deny2_r <= dy[DW-1] ? -dy : dy;
      lonx2_r <= dx[DW-1] ? dif_t'(s1x_r) - dif_t'(hi1x_r) : dif_t'(lo1x_r) - dif_t'(s1x_r);
      hinx2_r <= dx[DW-1] ? dif_t'(s1x_r) - dif_t'(lo1x_r) : dif_t'(hi1x_r) - dif_t'(s1x_r);
      lony2_r <= dy[DW-1] ? dif_t'(s1y_r) - dif_t'(hi1y_r) : dif_t'(lo1y_r) - dif_t'(s1y_r);
      hiny2_r <= dy[DW-1] ? dif_t'(s1y_r) - dif_t'(lo1y_r) : dif_t'(hi1y_r) - dif_t'(s1y_r);
    end
  end

  // stage 3: cross products for choosing the entry and exit bounds
  logic v3_r, in3_r, miss3_r, bx3_r, by3_r;
  dif_t lonx3_r, hinx3_r, denx3_r, lony3_r, hiny3_r, deny3_r;
  prd_t pl0_r, pl1_r, ph0_r, ph1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in3_r   <= in2_r;
      miss3_r <= miss2_r;
      bx3_r   <= bx2_r;
      by3_r   <= by2_r;
      lonx3_r <= lonx2_r;
      hinx3_r <= hinx2_r;
      denx3_r <= denx2_r;
      lony3_r <= lony2_r;
      hiny3_r <= hiny2_r;
      deny3_r <= deny2_r;
      pl0_r   <= prd_t'(lonx2_r) * prd_t'(deny2_r);
      pl1_r   <= prd_t'(lony2_r) * prd_t'(denx2_r);
      ph0_r   <= prd_t'(hinx2_r) * prd_t'(deny2_r);
      ph1_r   <= prd_t'(hiny2_r) * prd_t'(denx2_r);
    end
  end

  // stage 4: pick tmin and tmax
  logic v4_r, in4_r, ok4_r;
  dif_t tmn4_r, tmd4_r, txn4_r, txd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    logic xl, xh;
    dif_t tmn, tmd, txn, txd;
    if (adv) begin
      xl = (cmp3(pl0_r, pl1_r) != CMP_LT);
      xh = (cmp3(ph0_r, ph1_r) != CMP_GT);
      if (bx3_r && by3_r) begin
        tmn = xl ? lonx3_r : lony3_r;
        tmd = xl ? denx3_r : deny3_r;
        txn = xh ? hinx3_r : hiny3_r;
        txd = xh ? denx3_r : deny3_r;
      end else if (bx3_r) begin
        tmn = lonx3_r;
        tmd = denx3_r;
        txn = hinx3_r;
        txd = denx3_r;
      end else begin
        tmn = lony3_r;
        tmd = deny3_r;
        txn = hiny3_r;
        txd = deny3_r;
      end
      in4_r  <= in3_r;
      ok4_r  <= !miss3_r && (bx3_r || by3_r);
      tmn4_r <= tmn;
      tmd4_r <= tmd;
      txn4_r <= txn;
      txd4_r <= txd;
    end
  end

  // stage 5: tmin versus tmax cross products
  logic v5_r, in5_r, ok5_r;
  dif_t tmn5_r, tmd5_r, txn5_r, txd5_r;
  prd_t q0_r, q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in5_r  <= in4_r;
      ok5_r  <= ok4_r;
      tmn5_r <= tmn4_r;
      tmd5_r <= tmd4_r;
      txn5_r <= txn4_r;
      txd5_r <= txd4_r;
      q0_r   <= prd_t'(tmn4_r) * prd_t'(txd4_r);
      q1_r   <= prd_t'(txn4_r) * prd_t'(tmd4_r);
    end
  end

  // stage 6: final decision into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    logic order_ok, slab;
    dif_t tn, td;
    if (adv) begin
      order_ok = !txn5_r[DW-1] && (cmp3(q0_r, q1_r) != CMP_GT);
      tn = tmn5_r[DW-1] ? txn5_r : tmn5_r;
      td = tmn5_r[DW-1] ? txd5_r : tmd5_r;
      slab = ok5_r && order_ok && (tn > '0) && (tn < td);
      out_hit <= in5_r || slab;
    end
  end

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit))
    else $error("held result changed");

  // input is stalled exactly when the output stalls a valid result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // an endpoint inside the box always gives a hit
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v5_r && in5_r |=> out_valid && out_hit)
    else $error("inside endpoint missed");

  // a slab crossing needs a positive denominator
  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && ok4_r |-> tmd4_r > '0 && txd4_r > '0)
    else $error("bad slab denominator");

endmodule
